// File: rtl/ale_pkg.sv
// shared types and codes for the array list engine
package ale_pkg;

   localparam int MODE_WIDTH     = 3;
   localparam int POSITION_WIDTH = 6;
   localparam int VALUE_WIDTH    = 16;
   localparam int LENGTH_WIDTH   = 7;
   localparam int ERROR_WIDTH    = 2;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_READ        = 3'd0,
      MODE_WRITE       = 3'd1,
      MODE_INSERT_AT   = 3'd2,
      MODE_APPEND      = 3'd3,
      MODE_DELETE_AT   = 3'd4,
      MODE_DELETE_LAST = 3'd5,
      MODE_SEARCH      = 3'd6,
      MODE_CLEAR       = 3'd7
   } mode_type;

   typedef enum logic [ERROR_WIDTH-1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_INDEX = 2'd2,
      ERR_EMPTY = 2'd3
   } error_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_DELETE,
      CELL_SEARCH,
      CELL_READ
   } cell_op_type;

   typedef struct packed {
      logic        load;
      cell_op_type op;
   } cell_ctrl_type;

endpackage

// File: rtl/ale_if.sv
// request and response channel interfaces
interface ale_req_if;
   import ale_pkg::*;

   logic                             valid;
   logic                             ready;
   logic        [MODE_WIDTH-1:0]     mode;
   logic        [POSITION_WIDTH-1:0] position;
   logic signed [VALUE_WIDTH-1:0]    item_value;

   modport source (output valid, output mode, output position, output item_value,
                   input ready);
   modport sink (input valid, input mode, input position, input item_value,
                 output ready);
endinterface

interface ale_rsp_if;
   import ale_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] read_value;
   logic                          found;
   logic        [LENGTH_WIDTH-1:0] list_length;
   logic        [ERROR_WIDTH-1:0]  error_code;

   modport source (output valid, output read_value, output found, output list_length,
                   output error_code, input ready);
   modport sink (input valid, input read_value, input found, input list_length,
                 input error_code, output ready);
endinterface

// File: rtl/ale_cell.sv
// one list entry: shifts with its neighbors, compares and selects for read
module ale_cell #(
   parameter int ELEMENT_WIDTH = 16,
   parameter int INDEX_WIDTH   = 7,
   parameter int COUNT_WIDTH   = 7,
   parameter int INDEX         = 0
) (
   input  logic                         clock,
   input  ale_pkg::cell_ctrl_type       ctrl,
   input  logic [INDEX_WIDTH-1:0]       position,
   input  logic [COUNT_WIDTH-1:0]       count,
   input  logic [ELEMENT_WIDTH-1:0]     item_value,
   input  logic [ELEMENT_WIDTH-1:0]     left_in,
   input  logic [ELEMENT_WIDTH-1:0]     right_in,
   output logic [ELEMENT_WIDTH-1:0]     value_out,
   output logic                         hit,
   output logic [ELEMENT_WIDTH-1:0]     sel_value
);
   import ale_pkg::*;

   localparam logic [INDEX_WIDTH-1:0] MyIndex = INDEX_WIDTH'(INDEX);

   logic [ELEMENT_WIDTH-1:0] value_ff, value_in;
   logic                     hit_ff, hit_in;
   logic [ELEMENT_WIDTH-1:0] sel_value_ff, sel_value_in;
   logic                     at_pos, above_pos, below_count;

   assign at_pos      = MyIndex == position;
   assign above_pos   = MyIndex > position;
   assign below_count = MyIndex < INDEX_WIDTH'(count);

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         CELL_WRITE: begin
            if (at_pos) value_in = item_value;
         end
         CELL_INSERT: begin
            if (at_pos) value_in = item_value;
            else if (above_pos) value_in = left_in;
         end
         CELL_DELETE: begin
            if (at_pos || above_pos) value_in = right_in;
         end
         default: value_in = value_ff;
      endcase
   end

   assign hit_in       = (ctrl.op == CELL_SEARCH) && below_count && (value_ff == item_value);
   assign sel_value_in = ((ctrl.op == CELL_READ) && at_pos) ? value_ff : '0;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (ctrl.load) begin
         hit_ff       <= hit_in;
         sel_value_ff <= sel_value_in;
      end
   end

   assign value_out = value_ff;
   assign hit       = hit_ff;
   assign sel_value = sel_value_ff;

endmodule

// File: rtl/array_list_engine_core.sv
// Ordered list engine built as a row of entry cells. One request is accepted per cycle
// while the response side keeps up. At the transfer every cell shifts, writes and
// compares at once and registers its search hit and read selection; then, once the
// response register is free, the hits and selections are combined into it. Count checks
// and error codes are settled at the request transfer. Entries hold ELEMENT_WIDTH bits;
// items are sign-extended or truncated on the way in and out. No clearing pass: entries
// at or above the count are never read.
module array_list_engine_core #(
   parameter int CAPACITY      = 64,
   parameter int ELEMENT_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   ale_req_if.sink   req_ch,
   ale_rsp_if.source rsp_ch
);
   import ale_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CW > POSITION_WIDTH) ? CW : POSITION_WIDTH;

   logic [CW-1:0]             count_ff, count_in;
   logic                      s1_valid_ff;
   logic [LENGTH_WIDTH-1:0]   s1_len_ff;
   error_type                 s1_err_ff;
   logic                      rsp_valid_ff;
   logic [VALUE_WIDTH-1:0]    rsp_read_ff;
   logic                      rsp_found_ff;
   logic [LENGTH_WIDTH-1:0]   rsp_len_ff;
   error_type                 rsp_err_ff;

   logic                      accept, s1_move;
   logic                      full, empty;
   logic [IW-1:0]             pos_w, cnt_w, cell_pos;
   cell_op_type               op;
   error_type                 err;
   cell_ctrl_type             ctrl;
   logic [63:0]               item_wide;
   logic [ELEMENT_WIDTH-1:0]  item_elem;

   logic [ELEMENT_WIDTH-1:0]  cell_value [CAPACITY];
   logic [ELEMENT_WIDTH-1:0]  cell_sel   [CAPACITY];
   logic [CAPACITY-1:0]       cell_hit;
   logic [ELEMENT_WIDTH-1:0]  rd_or;
   logic signed [ELEMENT_WIDTH-1:0] rd_elem;
   logic [63:0]               rd_wide;

   assign s1_move      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_move;
   assign accept       = req_ch.valid && req_ch.ready;

   assign item_wide = 64'(req_ch.item_value);
   assign item_elem = item_wide[ELEMENT_WIDTH-1:0];

   assign pos_w = IW'(req_ch.position);
   assign cnt_w = IW'(count_ff);
   assign full  = count_ff == CW'(CAPACITY);
   assign empty = count_ff == '0;

   // request decode and count update
   always_comb begin
      op       = CELL_HOLD;
      err      = ERR_OK;
      cell_pos = pos_w;
      count_in = count_ff;
      case (mode_type'(req_ch.mode))
         MODE_READ: begin
            if (pos_w < cnt_w) op = CELL_READ;
            else err = ERR_INDEX;
         end
         MODE_WRITE: begin
            if (pos_w < cnt_w) op = CELL_WRITE;
            else err = ERR_INDEX;
         end
         MODE_INSERT_AT: begin
            if (full) err = ERR_FULL;
            else if (pos_w > cnt_w) err = ERR_INDEX;
            else begin
               op       = CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         MODE_APPEND: begin
            if (full) err = ERR_FULL;
            else begin
               op       = CELL_WRITE;
               cell_pos = cnt_w;
               count_in = count_ff + 1'b1;
            end
         end
         MODE_DELETE_AT: begin
            if (empty) err = ERR_EMPTY;
            else if (pos_w >= cnt_w) err = ERR_INDEX;
            else begin
               op       = CELL_DELETE;
               count_in = count_ff - 1'b1;
            end
         end
         MODE_DELETE_LAST: begin
            if (empty) err = ERR_EMPTY;
            else count_in = count_ff - 1'b1;
         end
         MODE_SEARCH: op = CELL_SEARCH;
         MODE_CLEAR:  count_in = '0;
         default:     op = CELL_HOLD;
      endcase
   end

   assign ctrl.load = accept;
   assign ctrl.op   = accept ? op : CELL_HOLD;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ELEMENT_WIDTH-1:0] left_value, right_value;
      if (g == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_left
         assign left_value = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_mid_right
         assign right_value = cell_value[g+1];
      end
      ale_cell #(
         .ELEMENT_WIDTH (ELEMENT_WIDTH),
         .INDEX_WIDTH   (IW),
         .COUNT_WIDTH   (CW),
         .INDEX         (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .position   (cell_pos),
         .count      (count_ff),
         .item_value (item_elem),
         .left_in    (left_value),
         .right_in   (right_value),
         .value_out  (cell_value[g]),
         .hit        (cell_hit[g]),
         .sel_value  (cell_sel[g])
      );
   end

   always_comb begin
      rd_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_or = rd_or | cell_sel[i];
      end
   end

   assign rd_elem = rd_or;
   assign rd_wide = 64'(rd_elem);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) count_ff <= count_in;
         if (accept) s1_valid_ff <= 1'b1;
         else if (s1_move) s1_valid_ff <= 1'b0;
         if (s1_move) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_len_ff <= LENGTH_WIDTH'(count_in);
         s1_err_ff <= err;
      end
      if (s1_move) begin
         rsp_read_ff  <= rd_wide[VALUE_WIDTH-1:0];
         rsp_found_ff <= |cell_hit;
         rsp_len_ff   <= s1_len_ff;
         rsp_err_ff   <= s1_err_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_value  = rsp_read_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.list_length = rsp_len_ff;
   assign rsp_ch.error_code  = rsp_err_ff;

endmodule

// File: rtl/ale_checker.sv
// port-level checks on the array list engine response stream
module ale_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [ale_pkg::VALUE_WIDTH-1:0]       rsp_read_value,
   input logic                                  rsp_found,
   input logic [ale_pkg::LENGTH_WIDTH-1:0]      rsp_list_length,
   input logic [ale_pkg::ERROR_WIDTH-1:0]       rsp_error_code
);
   import ale_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_found) && $stable(rsp_list_length) && $stable(rsp_error_code))
      else $error("response changed while stalled");

   // nonzero read data only on a successful read
   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_value != '0) |-> (rsp_error_code == ERR_OK) && !rsp_found)
      else $error("read data with error or found flag");

   // a hit needs a stored entry
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (rsp_error_code == ERR_OK) && (rsp_list_length != '0))
      else $error("found flag on empty list or with error");

   // empty error only on an empty list
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == ERR_EMPTY) |-> rsp_list_length == '0)
      else $error("empty error with nonzero length");

endmodule

bind array_list_engine_core ale_checker u_ale_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_read_value  (rsp_ch.read_value),
   .rsp_found       (rsp_ch.found),
   .rsp_list_length (rsp_ch.list_length),
   .rsp_error_code  (rsp_ch.error_code)
);
